[src/nsd_pkg.sv]
package nsd_pkg;

    localparam int FLOOR_W  = 4;
    localparam int PW_W     = 8;
    localparam int ML_W     = 10;
    localparam int IT_W     = 8;
    localparam int OCNT_W   = 5;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam int NUM_FLOORS_DEF  = 8;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PW_MAX          = 255;

    localparam logic [PW_W-1:0]    PW_RST      = 8'd70;
    localparam logic [ML_W-1:0]    ML_RST      = 10'd600;
    localparam logic [IT_W-1:0]    IT_RST      = 8'd50;
    localparam logic [ML_W-1:0]    LOAD_SAT    = 10'd1023;
    localparam logic [OCNT_W-1:0]  OCNT_SAT    = 5'd31;
    localparam logic [FLOOR_W-1:0] HOME_FLOOR  = 4'd1;

    // register index, taken from paddr word offset
    localparam logic [1:0] REG_PW       = 2'd0;
    localparam logic [1:0] REG_MAX_LOAD = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic CMD_CALL = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        EV_STORED  = 3'd0,
        EV_FULL    = 3'd1,
        EV_SERVED  = 3'd2,
        EV_HOME    = 3'd3,
        EV_IDLE    = 3'd4,
        EV_NOTHING = 3'd5
    } t_event;

    typedef struct packed {
        logic               command;
        logic [FLOOR_W-1:0] from_floor;
        logic [FLOOR_W-1:0] to_floor;
    } t_item;

    typedef struct packed {
        t_event             event_res;
        logic [FLOOR_W-1:0] car_floor;
        logic [ML_W-1:0]    load_kg;
        logic [OCNT_W-1:0]  exited_count;
        logic [OCNT_W-1:0]  boarded_count;
        logic [OCNT_W-1:0]  waiting_count;
    } t_result;

    typedef struct packed {
        logic               riding;
        logic [FLOOR_W-1:0] origin;
        logic [FLOOR_W-1:0] dest;
    } t_entry;

    typedef struct packed {
        logic [PW_W-1:0] passenger_weight;
        logic [ML_W-1:0] max_load;
        logic [IT_W-1:0] idle_timeout;
    } t_cfg;

endpackage

[src/nsd_mem.sv]
module nsd_mem
    import nsd_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/nsd_regs.sv]
module nsd_regs
    import nsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx  = i_paddr[CFG_AW-1:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.passenger_weight <= PW_RST;
            r_cfg.max_load         <= ML_RST;
            r_cfg.idle_timeout     <= IT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PW:       r_cfg.passenger_weight <= i_pwdata[PW_W-1:0];
                REG_MAX_LOAD: r_cfg.max_load         <= i_pwdata[ML_W-1:0];
                REG_TIMEOUT:  r_cfg.idle_timeout     <= i_pwdata[IT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_PW:       o_prdata = CFG_DW'(r_cfg.passenger_weight);
            REG_MAX_LOAD: o_prdata = CFG_DW'(r_cfg.max_load);
            REG_TIMEOUT:  o_prdata = CFG_DW'(r_cfg.idle_timeout);
            default:      o_prdata = '0;
        endcase
    end

endmodule

[src/nsd_ctrl.sv]
module nsd_ctrl
    import nsd_pkg::*;
#(
    parameter int NUM_FLOORS  = NUM_FLOORS_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  t_item                          i_item,
    output logic                           o_done,
    output t_result                        o_result,
    input  t_cfg                           i_cfg,
    output logic                           o_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_waddr,
    output t_entry                         o_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_raddr,
    input  t_entry                         i_rdata
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int FI_W     = $clog2(NUM_FLOORS + 1);
    localparam int LOAD_RAW = $clog2(TABLE_DEPTH * PW_MAX + 1);
    localparam int LOAD_W   = (LOAD_RAW > ML_W) ? LOAD_RAW : ML_W;
    localparam int MUL_W    = CNT_W + PW_W;
    localparam int DIST_W   = FLOOR_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_SCAN,
        S_PICK,
        S_NLOAD,
        S_MOVE,
        S_FIN
    } t_state;

    function automatic logic [FLOOR_W-1:0] floor_gap(input logic [FLOOR_W-1:0] a,
                                                     input logic [FLOOR_W-1:0] b);
        floor_gap = (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W+OCNT_W-1:0] w;
        w = (CNT_W + OCNT_W)'(v);
        sat_cnt = (w > (CNT_W + OCNT_W)'(OCNT_SAT)) ? OCNT_SAT : w[OCNT_W-1:0];
    endfunction

    function automatic logic [ML_W-1:0] sat_load(input logic [LOAD_W-1:0] v);
        sat_load = (v > LOAD_W'(LOAD_SAT)) ? LOAD_SAT : v[ML_W-1:0];
    endfunction

    t_state             r_state;
    t_item              r_item;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_riders;
    logic [CNT_W-1:0]   r_waiting;
    logic [FLOOR_W-1:0] r_floor;
    logic [IT_W-1:0]    r_idle;
    logic [LOAD_W-1:0]  r_load;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_wp;
    logic [DIST_W-1:0]  r_best_r;
    logic [DIST_W-1:0]  r_best_w;
    logic [FLOOR_W-1:0] r_tgt_r;
    logic [FLOOR_W-1:0] r_tgt_w;
    logic [LOAD_W-1:0]  r_tmp;
    logic [FLOOR_W-1:0] r_target;
    logic [LOAD_W-1:0]  r_nload;
    logic [CNT_W-1:0]   r_exited;
    logic [CNT_W-1:0]   r_boarded;
    logic [CNT_W-1:0]   r_dcnt [NUM_FLOORS+1];
    logic               r_done;
    t_result            r_result;

    logic [LOAD_W-1:0]  pw_ext;
    logic [LOAD_W-1:0]  load_prod;
    logic [LOAD_W-1:0]  nload_prod;
    logic [CNT_W-1:0]   stay_riders;
    logic               proc;
    logic               is_last;
    logic               fits_scan;
    logic               fits_move;
    logic               call_ok;
    logic               tasks;
    logic               hit_exit;
    logic               hit_board;
    logic [DIST_W-1:0]  d_dest;
    logic [DIST_W-1:0]  d_org;
    logic [IT_W-1:0]    n_idle;
    logic [FLOOR_W-1:0] n_target;
    logic [CNT_W-1:0]   n_waiting_call;
    logic [CNT_W-1:0]   n_waiting_fin;
    t_entry             ent;

    assign ent      = i_rdata;
    assign pw_ext   = LOAD_W'(i_cfg.passenger_weight);
    // read data of the previous address is in hand on every pass cycle but the first
    assign proc     = (r_idx != '0);
    assign is_last  = (r_idx == r_used);

    assign load_prod   = LOAD_W'(MUL_W'(r_riders) * MUL_W'(i_cfg.passenger_weight));
    assign stay_riders = r_riders - r_dcnt[r_target[FI_W-1:0]];
    assign nload_prod  = LOAD_W'(MUL_W'(stay_riders) * MUL_W'(i_cfg.passenger_weight));

    assign fits_scan = ((LOAD_W + 1)'(r_tmp) + (LOAD_W + 1)'(pw_ext))
                       <= (LOAD_W + 1)'(i_cfg.max_load);
    assign fits_move = ((LOAD_W + 1)'(r_nload) + (LOAD_W + 1)'(pw_ext))
                       <= (LOAD_W + 1)'(i_cfg.max_load);

    assign call_ok = (r_item.from_floor >= HOME_FLOOR)
                  && (r_item.from_floor <= FLOOR_W'(NUM_FLOORS))
                  && (r_item.to_floor >= HOME_FLOOR)
                  && (r_item.to_floor <= FLOOR_W'(NUM_FLOORS));

    // with an empty car the load check of a waiting passenger reduces to weight vs limit
    assign tasks = (r_riders != '0)
                || ((r_waiting != '0) && (ML_W'(i_cfg.passenger_weight) <= i_cfg.max_load));

    assign d_dest = DIST_W'(floor_gap(ent.dest, r_floor));
    assign d_org  = DIST_W'(floor_gap(ent.origin, r_floor));

    assign n_idle   = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    // riders win ties, a waiting origin must be strictly nearer
    assign n_target = (r_best_w < r_best_r) ? r_tgt_w : r_tgt_r;

    assign hit_exit  = ent.riding && (ent.dest == r_target);
    assign hit_board = !ent.riding && (ent.origin == r_target) && fits_move;

    assign n_waiting_call = r_waiting + 1'b1;
    assign n_waiting_fin  = r_waiting - r_boarded;

    always_comb begin
        o_raddr = r_idx[AW-1:0];
        o_we    = 1'b0;
        o_waddr = r_wp[AW-1:0];
        o_wdata = ent;
        if (hit_board) begin
            o_wdata.riding = 1'b1;
        end
        unique case (r_state)
            S_EXEC: begin
                o_waddr = r_used[AW-1:0];
                o_wdata = '{riding: 1'b0, origin: r_item.from_floor, dest: r_item.to_floor};
                o_we    = (r_item.command == CMD_CALL) && call_ok
                       && (r_used != CNT_W'(TABLE_DEPTH));
            end
            S_MOVE: begin
                // survivors are written back packed toward the front
                o_we = proc && !hit_exit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            for (int f = 0; f <= NUM_FLOORS; f++) begin
                r_dcnt[f] <= '0;
            end
        end else if ((r_state == S_SCAN) && proc && ent.riding) begin
            r_dcnt[ent.dest[FI_W-1:0]] <= r_dcnt[ent.dest[FI_W-1:0]] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_used    <= '0;
            r_riders  <= '0;
            r_waiting <= '0;
            r_floor   <= HOME_FLOOR;
            r_idle    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_load  <= load_prod;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_result.car_floor     <= r_floor;
                    r_result.load_kg       <= sat_load(r_load);
                    r_result.exited_count  <= '0;
                    r_result.boarded_count <= '0;
                    r_result.waiting_count <= sat_cnt(r_waiting);
                    if (r_item.command == CMD_CALL) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (!call_ok) begin
                            r_result.event_res <= EV_NOTHING;
                        end else if (r_used == CNT_W'(TABLE_DEPTH)) begin
                            r_result.event_res <= EV_FULL;
                        end else begin
                            r_used                 <= r_used + 1'b1;
                            r_waiting              <= n_waiting_call;
                            r_result.event_res     <= EV_STORED;
                            r_result.waiting_count <= sat_cnt(n_waiting_call);
                        end
                    end else if (!tasks) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if ((r_waiting != '0) || (r_floor == HOME_FLOOR)) begin
                            r_idle             <= '0;
                            r_result.event_res <= EV_NOTHING;
                        end else if (n_idle >= i_cfg.idle_timeout) begin
                            r_idle             <= '0;
                            r_floor            <= HOME_FLOOR;
                            r_result.car_floor <= HOME_FLOOR;
                            r_result.event_res <= EV_HOME;
                        end else begin
                            r_idle             <= n_idle;
                            r_result.event_res <= EV_IDLE;
                        end
                    end else begin
                        r_idx    <= '0;
                        r_best_r <= '1;
                        r_best_w <= '1;
                        r_tgt_r  <= r_floor;
                        r_tgt_w  <= r_floor;
                        r_tmp    <= r_load;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (proc) begin
                        if (ent.riding) begin
                            if (d_dest < r_best_r) begin
                                r_best_r <= d_dest;
                                r_tgt_r  <= ent.dest;
                            end
                        end else if (fits_scan) begin
                            if (d_org < r_best_w) begin
                                r_best_w <= d_org;
                                r_tgt_w  <= ent.origin;
                            end
                            r_tmp <= r_tmp + pw_ext;
                        end
                    end
                    if (is_last) begin
                        r_state <= S_PICK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_PICK: begin
                    r_target <= n_target;
                    r_state  <= S_NLOAD;
                end
                S_NLOAD: begin
                    r_nload   <= nload_prod;
                    r_idx     <= '0;
                    r_wp      <= '0;
                    r_exited  <= '0;
                    r_boarded <= '0;
                    r_state   <= S_MOVE;
                end
                S_MOVE: begin
                    if (proc) begin
                        if (hit_exit) begin
                            r_exited <= r_exited + 1'b1;
                        end else begin
                            r_wp <= r_wp + 1'b1;
                            if (hit_board) begin
                                r_nload   <= r_nload + pw_ext;
                                r_boarded <= r_boarded + 1'b1;
                            end
                        end
                    end
                    if (is_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    r_used                 <= r_wp;
                    r_riders               <= r_riders - r_exited + r_boarded;
                    r_waiting              <= n_waiting_fin;
                    r_floor                <= r_target;
                    r_idle                 <= '0;
                    r_done                 <= 1'b1;
                    r_result.event_res     <= EV_SERVED;
                    r_result.car_floor     <= r_target;
                    r_result.load_kg       <= sat_load(r_nload);
                    r_result.exited_count  <= sat_cnt(r_exited);
                    r_result.boarded_count <= sat_cnt(r_boarded);
                    r_result.waiting_count <= sat_cnt(n_waiting_fin);
                    r_state                <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[src/elevator_nearest_stop_dispatcher_core.sv]
// channel   direction  handshake                     payload
// command   in         start high, busy low          i_item (t_item)
// result    out        o_done strobe, one cycle      o_result (t_result)
// config    in/out     apb: psel, penable, pwrite    paddr, pwdata, prdata
//
// a call beat, or a tick with nothing to serve, passes through the load and exec states
// after acceptance and ends with its o_done strobe
// a service tick runs load, exec, scan, pick, nload, move and fin, with two passes over
// the passenger table (scan, then move) through its single read port
// reset leaves the car on floor 1 with an empty table; the table has a fill count and no
// clearing pass, so items are taken right after reset
// the result is shown for one cycle only and the receiver cannot stall it
module elevator_nearest_stop_dispatcher_core
    import nsd_pkg::*;
#(
    parameter int NUM_FLOORS  = NUM_FLOORS_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cfg            cfg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_rdata;

    nsd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    nsd_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    nsd_ctrl #(
        .NUM_FLOORS  (NUM_FLOORS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .i_cfg    (cfg),
        .o_we     (mem_we),
        .o_waddr  (mem_waddr),
        .o_wdata  (mem_wdata),
        .o_raddr  (mem_raddr),
        .i_rdata  (mem_rdata)
    );

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted command");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in flight");

    a_counts_only_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.event_res != EV_SERVED))
            |-> (o_result.exited_count == '0) && (o_result.boarded_count == '0))
        else $error("exit or board count on a step that served no stop");

    a_home_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.event_res == EV_HOME)) |-> (o_result.car_floor == HOME_FLOOR))
        else $error("return home left the car off floor one");

endmodule
